### rtl/core/mzr_pkg.sv
// Shared constants, types and state codes of the max zero rectangle finder.
package mzr_pkg;

   localparam int MAX_ROWS = 256;
   localparam int MAX_COLS = 256;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int SIZE_W = 9;
   localparam int AREA_W = 17;
   localparam int PIX_W  = 1;

   localparam int HIST_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int HIST_AW    = ROW_W + COL_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = CSR_IDX_W'(1);

   localparam logic [SIZE_W-1:0] ROWS_LIMIT = SIZE_W'(MAX_ROWS);
   localparam logic [SIZE_W-1:0] COLS_LIMIT = SIZE_W'(MAX_COLS);

   typedef struct packed {
      logic [COL_W-1:0]  left;
      logic [ROW_W-1:0]  top;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic [AREA_W-1:0] area;
   } rect_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEIGHT,
      ST_WALK,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

### rtl/core/mzr_best.sv
// Candidate stage and best-rectangle register with strict-greater update.
module mzr_best (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              cand_valid,
   input  mzr_pkg::rect_type cand,
   output mzr_pkg::rect_type best
);
   import mzr_pkg::*;

   logic     cand_valid_ff;
   rect_type cand_ff;
   rect_type best_ff;
   rect_type best_in;

   // Keep the first rectangle on a tie: replace only on a strictly larger area.
   always_comb begin
      best_in = best_ff;
      if (clear) begin
         best_in = '0;
      end else if (cand_valid_ff && (cand_ff.area > best_ff.area)) begin
         best_in = cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
         best_ff       <= '0;
      end else begin
         cand_valid_ff <= cand_valid && !clear;
         best_ff       <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand;
   end

   assign best = best_ff;

endmodule

### rtl/core/max_zero_rectangle_finder.sv
// Top level of the max zero rectangle finder: control, memories and channels.
//
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+---------------------------
//  req     | req_valid/ready, req_pixel     | in        | one pixel, raster order
//  rsp     | rsp_valid/ready, rsp_rect_*    | out       | best rectangle per frame
//  csr     | csr_valid/ready, index, data   | in        | frame_rows / frame_cols
//
// Each pixel is taken in ST_IDLE and the column height memory is read; ST_HEIGHT
// then updates it and writes the run width history, ST_WALK walks up the history
// memory one read per cycle for the zero run height h of its column (at most
// MAX_ROWS), and ST_DRAIN drains the candidate compare. After the last pixel of a
// frame, ST_EMIT loads the result register; this holds while an earlier result
// still waits on rsp_ready.
// Reset is synchronous; the column heights clear at once through a valid bit
// per column, the history memory is never cleared and needs no pass.
// req and csr are taken only between pixels; a csr write has priority.
module max_zero_rectangle_finder (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mzr_pkg::PIX_W-1:0]           req_pixel,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mzr_pkg::COL_W-1:0]           rsp_rect_left,
   output logic [mzr_pkg::ROW_W-1:0]           rsp_rect_top,
   output logic [mzr_pkg::SIZE_W-1:0]          rsp_rect_width,
   output logic [mzr_pkg::SIZE_W-1:0]          rsp_rect_height,
   output logic [mzr_pkg::AREA_W-1:0]          rsp_rect_area,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mzr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mzr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mzr_pkg::*;

   state_type state_ff, state_in;

   // Configuration registers and their clamped frame size.
   logic [SIZE_W-1:0] frame_rows_ff, frame_cols_ff;
   logic [SIZE_W-1:0] rows_eff, cols_eff;

   // Per-pixel context.
   logic              free_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [SIZE_W-1:0] rrw_ff;
   logic [SIZE_W-1:0] walk_h_ff, walk_h_in;
   logic [SIZE_W-1:0] k_ff;
   logic [SIZE_W-1:0] minw_ff;

   // Column height memory with a valid bit per column.
   logic [SIZE_W-1:0] height_mem [MAX_COLS];
   logic [SIZE_W-1:0] height_q_ff;
   logic [MAX_COLS-1:0] hvalid_ff;

   // Run width history memory, one entry per pixel.
   logic [SIZE_W-1:0]  hist_mem [HIST_DEPTH];
   logic [SIZE_W-1:0]  hist_q_ff;
   logic [HIST_AW-1:0] hist_wr_addr, hist_rd_addr;
   logic [SIZE_W-1:0]  rd_k;

   // Result register.
   logic     rsp_valid_ff;
   rect_type rsp_ff;

   // Control decodes.
   logic req_fire, csr_fire, csr_known, frame_clear, emit_load;
   logic cand_valid;
   logic update_en, advance_en;

   // Datapath values.
   logic [SIZE_W-1:0]   h_old, new_h, new_w, rows_here;
   logic [SIZE_W-1:0]   minw_new, k_plus;
   logic [2*SIZE_W-1:0] prod;
   logic [SIZE_W-1:0]   col_next, row_next;
   logic                row_wrap, frame_end;
   rect_type            cand, best;

   // ---------------------------------------------------------------- sizes
   always_comb begin
      if (frame_rows_ff == '0) begin
         rows_eff = SIZE_W'(1);
      end else if (frame_rows_ff > ROWS_LIMIT) begin
         rows_eff = ROWS_LIMIT;
      end else begin
         rows_eff = frame_rows_ff;
      end
      if (frame_cols_ff == '0) begin
         cols_eff = SIZE_W'(1);
      end else if (frame_cols_ff > COLS_LIMIT) begin
         cols_eff = COLS_LIMIT;
      end else begin
         cols_eff = frame_cols_ff;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      // Column height and row run width for the current pixel.
      h_old     = hvalid_ff[col_ff] ? height_q_ff : '0;
      new_h     = free_ff ? (h_old + SIZE_W'(1)) : '0;
      new_w     = free_ff ? (((col_ff == '0) ? '0 : rrw_ff) + SIZE_W'(1)) : '0;
      rows_here = SIZE_W'(row_ff) + SIZE_W'(1);
      walk_h_in = (new_h > rows_here) ? rows_here : new_h;

      // One history entry per cycle while walking up the column.
      minw_new = (hist_q_ff < minw_ff) ? hist_q_ff : minw_ff;
      k_plus   = k_ff + SIZE_W'(1);
      prod     = k_plus * minw_new;

      // Row zero of the walk is the entry just written, so take it directly.
      if (state_ff == ST_HEIGHT) begin
         cand.area   = AREA_W'(new_w);
         cand.width  = new_w;
         cand.height = SIZE_W'(1);
         cand.left   = COL_W'(SIZE_W'(col_ff) + SIZE_W'(1) - new_w);
         cand.top    = row_ff;
      end else begin
         cand.area   = prod[AREA_W-1:0];
         cand.width  = minw_new;
         cand.height = k_plus;
         cand.left   = COL_W'(SIZE_W'(col_ff) + SIZE_W'(1) - minw_new);
         cand.top    = row_ff - k_ff[ROW_W-1:0];
      end

      rd_k         = (state_ff == ST_HEIGHT) ? SIZE_W'(1) : k_plus;
      hist_wr_addr = {row_ff, col_ff};
      hist_rd_addr = {row_ff - rd_k[ROW_W-1:0], col_ff};

      col_next  = SIZE_W'(col_ff) + SIZE_W'(1);
      row_next  = SIZE_W'(row_ff) + SIZE_W'(1);
      row_wrap  = (col_next >= cols_eff);
      frame_end = row_wrap && (row_next >= rows_eff);
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_HEIGHT;
            end
         end
         ST_HEIGHT: begin
            state_in = (walk_h_in > SIZE_W'(1)) ? ST_WALK : ST_DRAIN;
         end
         ST_WALK: begin
            if (k_plus >= walk_h_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = frame_end ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      csr_ready  = 1'b0;
      req_ready  = 1'b0;
      update_en  = 1'b0;
      cand_valid = 1'b0;
      advance_en = 1'b0;
      emit_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
         end
         ST_HEIGHT: begin
            update_en  = 1'b1;
            cand_valid = 1'b1;
         end
         ST_WALK: begin
            cand_valid = 1'b1;
         end
         ST_DRAIN: begin
            advance_en = !frame_end;
         end
         ST_EMIT: begin
            emit_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   assign req_fire    = req_valid && req_ready;
   assign csr_fire    = csr_valid && csr_ready;
   assign csr_known   = (csr_index == CSR_FRAME_ROWS) || (csr_index == CSR_FRAME_COLS);
   assign frame_clear = (csr_fire && csr_known) || emit_load;

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frame_rows_ff <= ROWS_LIMIT;
         frame_cols_ff <= COLS_LIMIT;
         row_ff        <= '0;
         col_ff        <= '0;
         rrw_ff        <= '0;
         hvalid_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_fire && (csr_index == CSR_FRAME_ROWS)) begin
            frame_rows_ff <= csr_data;
         end
         if (csr_fire && (csr_index == CSR_FRAME_COLS)) begin
            frame_cols_ff <= csr_data;
         end

         if (update_en) begin
            rrw_ff            <= new_w;
            hvalid_ff[col_ff] <= 1'b1;
         end

         // Step to the next pixel, wrapping at the row end.
         if (advance_en) begin
            if (row_wrap) begin
               col_ff <= '0;
               row_ff <= row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end

         // Drop the frame in progress and start over at row 0, column 0.
         if (frame_clear) begin
            row_ff    <= '0;
            col_ff    <= '0;
            rrw_ff    <= '0;
            hvalid_ff <= '0;
         end

         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- walk regs
   always_ff @(posedge clock) begin
      if (req_fire) begin
         free_ff <= (req_pixel[0] == 1'b0);
      end
      if (state_ff == ST_HEIGHT) begin
         walk_h_ff <= walk_h_in;
         minw_ff   <= new_w;
         k_ff      <= SIZE_W'(1);
      end else if (state_ff == ST_WALK) begin
         minw_ff <= minw_new;
         k_ff    <= k_plus;
      end
      if (emit_load) begin
         rsp_ff <= best;
      end
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (update_en) begin
         height_mem[col_ff] <= new_h;
      end
      height_q_ff <= height_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (update_en) begin
         hist_mem[hist_wr_addr] <= new_w;
      end
      hist_q_ff <= hist_mem[hist_rd_addr];
   end

   // ---------------------------------------------------------------- best
   mzr_best u_best (
      .clock      (clock),
      .reset      (reset),
      .clear      (frame_clear),
      .cand_valid (cand_valid),
      .cand       (cand),
      .best       (best)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_left   = rsp_ff.left;
   assign rsp_rect_top    = rsp_ff.top;
   assign rsp_rect_width  = rsp_ff.width;
   assign rsp_rect_height = rsp_ff.height;
   assign rsp_rect_area   = rsp_ff.area;

endmodule
